// ===== rtl/chol_pkg.sv =====
// shared constants, types and saturation helpers for the cholesky factor and solve block
// no dependencies
package chol_pkg;

  localparam int MAX_DIM   = 8;
  localparam int MAX_RHS   = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 4;
  localparam int ADDR_W    = 6;
  localparam int DEPTH_A   = MAX_DIM * MAX_DIM;
  localparam int DEPTH_B   = MAX_DIM * MAX_RHS;
  localparam int ACC_W     = 52;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SHF_W     = PROD_W - FRAC_BITS;
  localparam int DIV_W     = 48;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int REG_W     = 4;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHS = 2'd1;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic start;
    logic op_sqrt;
  } it_ctrl_t;

  // clamp a wide signed sum to the 32-bit range
  function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) return v[DATA_W-1:0];
    return v[ACC_W-1] ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic [ACC_W-1:0] sext_data(input logic [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // product shifted right by the fraction width, rounding toward minus infinity
  function automatic logic [ACC_W-1:0] qshift(input logic [PROD_W-1:0] p);
    return {{(ACC_W-SHF_W){p[PROD_W-1]}}, p[PROD_W-1:FRAC_BITS]};
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return {r, c};
  endfunction

endpackage

// ===== rtl/chol_if.sv =====
// valid/ready channel interfaces for the cholesky block: input, result, configuration
// depends on chol_pkg
interface chol_in_if;
  logic                          valid;
  logic                          ready;
  logic [chol_pkg::CMD_W-1:0]    command;
  logic [chol_pkg::IDX_W-1:0]    row;
  logic [chol_pkg::IDX_W-1:0]    col;
  logic signed [chol_pkg::DATA_W-1:0] value;
  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface chol_out_if;
  logic                          valid;
  logic                          ready;
  logic [chol_pkg::IDX_W-1:0]    out_row;
  logic [chol_pkg::IDX_W-1:0]    out_col;
  logic signed [chol_pkg::DATA_W-1:0] out_value;
  logic                          status;
  logic                          last;
  modport source (output valid, out_row, out_col, out_value, status, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

interface chol_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [chol_pkg::CFG_IDX_W-1:0]  index;
  logic [chol_pkg::DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/chol_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/chol_iter.sv =====
// iterative unit: integer square root (two radicand bits a step) or
// unsigned restoring division (one quotient bit a step); depends on chol_pkg
module chol_iter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chol_pkg::it_ctrl_t         ctrl,
  input  logic [chol_pkg::DIV_W-1:0] a,
  input  logic [chol_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [chol_pkg::DIV_W-1:0] res
);
  import chol_pkg::*;

  localparam int REM_W   = DATA_W + 2;
  localparam int ROOT_W  = DIV_W / 2;
  localparam int ITER_W  = $clog2(DIV_W);

  logic              busy_r;
  logic              done_r;
  logic              op_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DIV_W-1:0]  a_r;
  logic [DATA_W-1:0] b_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  res_r;

  logic [REM_W-1:0]  rem2;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem1;
  logic [REM_W-1:0]  dvs;

  always_comb begin
    rem2  = {rem_r[REM_W-3:0], a_r[DIV_W-1 -: 2]};
    trial = REM_W'({res_r[ROOT_W-1:0], 2'b01});
    rem1  = {rem_r[REM_W-2:0], a_r[DIV_W-1]};
    dvs   = REM_W'(b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_r   <= a;
      b_r   <= b;
      rem_r <= '0;
      res_r <= '0;
      op_r  <= ctrl.op_sqrt;
      cnt_r <= ctrl.op_sqrt ? ITER_W'(ROOT_W - 1) : ITER_W'(DIV_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (op_r) begin
        a_r <= {a_r[DIV_W-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem_r <= rem2 - trial;
          res_r <= {res_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2;
          res_r <= {res_r[DIV_W-2:0], 1'b0};
        end
      end else begin
        a_r <= {a_r[DIV_W-2:0], 1'b0};
        if (rem1 >= dvs) begin
          rem_r <= rem1 - dvs;
          res_r <= {res_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem1;
          res_r <= {res_r[DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

// ===== rtl/cholesky_factor_and_solve_top.sv =====
// top level of the cholesky factor and forward solve block
// depends on chol_pkg, chol_if, chol_ram and chol_iter
//
// The block keeps a symmetric matrix A and a right-hand side B (Q16.16) in two
// 64-entry rams. Load transfers write one element each, one per clock while the
// block is idle. A read transfer returns one stored element via the ram read
// register and the output register. A solve transfer factors A in place into
// upper triangular R (R^T R = A, lower triangle cleared), then solves R^T X = B
// column by column, overwrites B and emits X, rows in order, last marked; a
// negative pivot sum instead yields one result with status 1 at the failing
// pivot. The solve run is bound by one shared multiplier fed from single-read
// rams: each dot-product term steps through read, second read, multiply and
// accumulate states, and square roots and divisions (pivot reciprocal, solve
// quotient) run on the iterative unit. No new item is taken until a read or
// solve run has handed its last result to the output register; the output
// register frees the sequencer as soon as a result is parked.
module cholesky_factor_and_solve_top (
  input  logic clk,
  input  logic rst_n,
  chol_in_if.sink    in_ch,
  chol_out_if.source out_ch,
  chol_cfg_if.sink   cfg_ch
);
  import chol_pkg::*;

  // sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_RDOUT     = 5'd1;
  localparam logic [4:0] S_ZERO      = 5'd2;
  localparam logic [4:0] S_DLOAD     = 5'd3;
  localparam logic [4:0] S_DOT_X     = 5'd4;
  localparam logic [4:0] S_DOT_Y     = 5'd5;
  localparam logic [4:0] S_DOT_M     = 5'd6;
  localparam logic [4:0] S_DOT_A     = 5'd7;
  localparam logic [4:0] S_DIAG_END  = 5'd8;
  localparam logic [4:0] S_FAIL      = 5'd9;
  localparam logic [4:0] S_SQRT      = 5'd10;
  localparam logic [4:0] S_RECIP     = 5'd11;
  localparam logic [4:0] S_OFF_START = 5'd12;
  localparam logic [4:0] S_OFF_LD    = 5'd13;
  localparam logic [4:0] S_OFF_END   = 5'd14;
  localparam logic [4:0] S_OFF_MUL   = 5'd15;
  localparam logic [4:0] S_SOL_START = 5'd16;
  localparam logic [4:0] S_SOL_ROW   = 5'd17;
  localparam logic [4:0] S_SOL_LD    = 5'd18;
  localparam logic [4:0] S_SOL_END   = 5'd19;
  localparam logic [4:0] S_SOL_PIV   = 5'd20;
  localparam logic [4:0] S_SOL_DIV   = 5'd21;
  localparam logic [4:0] S_SOL_OUT   = 5'd22;
  localparam logic [4:0] S_EMPTY     = 5'd23;

  // which dot product is running
  localparam logic [1:0] MODE_DIAG  = 2'd0;
  localparam logic [1:0] MODE_OFF   = 2'd1;
  localparam logic [1:0] MODE_SOLVE = 2'd2;

  // configuration
  logic [REG_W-1:0] dim_r;
  logic [REG_W-1:0] rhs_r;

  // sequencer registers
  logic [4:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  c_r, c_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  m_r, m_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] dv_r, dv_nxt;
  logic [DATA_W-1:0] s_r, s_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic signed [PROD_W-1:0] prod_r;

  // output register
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_status_r;
  logic              out_last_r;

  logic              slot_free;
  logic              emit;
  logic [IDX_W-1:0]  e_row, e_col;
  logic [DATA_W-1:0] e_val;
  logic              e_st, e_last;

  // ram ports
  logic              m_we, m_re, b_we, b_re;
  logic [ADDR_W-1:0] m_waddr, m_raddr, b_waddr, b_raddr;
  logic [DATA_W-1:0] m_wdata, b_wdata, m_rdata, b_rdata;

  // shared multiplier and iterative unit
  logic signed [DATA_W-1:0] mul_a, mul_b;
  it_ctrl_t          it_ctrl;
  logic [DIV_W-1:0]  it_a;
  logic [DATA_W-1:0] it_b;
  logic              it_done;
  logic [DIV_W-1:0]  it_res;

  logic [IDX_W-1:0]  ii, jj, kk, cc;
  logic [DATA_W-1:0] s_sat;
  logic [DATA_W-1:0] s_abs;

  assign ii = i_r[IDX_W-1:0];
  assign jj = j_r[IDX_W-1:0];
  assign kk = k_r[IDX_W-1:0];
  assign cc = c_r[IDX_W-1:0];
  assign s_sat = sat32(acc_r);
  assign s_abs = s_r[DATA_W-1] ? (~s_r + 1'b1) : s_r;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH_A)) u_mat_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH_B)) u_rhs_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  chol_iter u_iter (
    .clk(clk), .rst_n(rst_n), .ctrl(it_ctrl), .a(it_a), .b(it_b),
    .done(it_done), .res(it_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= REG_W'(MAX_DIM);
      rhs_r <= REG_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DIM: dim_r <= cfg_ch.data[REG_W-1:0];
        REG_RHS: rhs_r <= cfg_ch.data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    dv_nxt    = dv_r;
    s_nxt     = s_r;
    res_nxt   = res_r;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_re = 1'b0; m_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;
    it_ctrl = '0;
    it_a    = '0;
    it_b    = '0;
    emit = 1'b0; e_row = '0; e_col = '0; e_val = '0; e_st = 1'b0; e_last = 1'b0;
    mul_a = x_r;
    mul_b = (mode_r == MODE_SOLVE) ? b_rdata : m_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.command)
            CMD_LOAD_A: begin
              m_we    = 1'b1;
              m_waddr = elem_addr(in_ch.row, in_ch.col);
              m_wdata = in_ch.value;
            end
            CMD_LOAD_B: begin
              b_we    = 1'b1;
              b_waddr = elem_addr(in_ch.row, in_ch.col);
              b_wdata = in_ch.value;
            end
            CMD_READ: begin
              m_re      = 1'b1;
              m_raddr   = elem_addr(in_ch.row, in_ch.col);
              i_nxt     = {1'b0, in_ch.row};
              j_nxt     = {1'b0, in_ch.col};
              state_nxt = S_RDOUT;
            end
            CMD_SOLVE: begin
              // clamp the order to [1, max] and the column count to [0, max]
              if (dim_r == '0) begin
                n_nxt = CNT_W'(1);
              end else if (dim_r > CNT_W'(MAX_DIM)) begin
                n_nxt = CNT_W'(MAX_DIM);
              end else begin
                n_nxt = dim_r;
              end
              m_nxt     = (rhs_r > CNT_W'(MAX_RHS)) ? CNT_W'(MAX_RHS) : rhs_r;
              i_nxt     = '0;
              k_nxt     = '0;
              state_nxt = S_ZERO;
            end
            default: ;
          endcase
        end
      end

      S_RDOUT: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_row     = ii;
          e_col     = jj;
          e_val     = m_rdata;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // clear the lower part of row i, then fetch the diagonal
      S_ZERO: begin
        if (k_r < i_r) begin
          m_we    = 1'b1;
          m_waddr = elem_addr(ii, kk);
          k_nxt   = k_r + 1'b1;
        end else begin
          m_re      = 1'b1;
          m_raddr   = elem_addr(ii, ii);
          state_nxt = S_DLOAD;
        end
      end

      S_DLOAD: begin
        acc_nxt   = sext_data(m_rdata);
        k_nxt     = '0;
        mode_nxt  = MODE_DIAG;
        state_nxt = S_DOT_X;
      end

      // shared dot product: acc -= R(k,i) * y(k) for k < i
      S_DOT_X: begin
        if (k_r == i_r) begin
          unique case (mode_r)
            MODE_DIAG: state_nxt = S_DIAG_END;
            MODE_OFF:  state_nxt = S_OFF_END;
            default:   state_nxt = S_SOL_END;
          endcase
        end else begin
          m_re      = 1'b1;
          m_raddr   = elem_addr(kk, ii);
          state_nxt = S_DOT_Y;
        end
      end

      S_DOT_Y: begin
        x_nxt = m_rdata;
        unique case (mode_r)
          MODE_DIAG: begin
            m_re    = 1'b1;
            m_raddr = elem_addr(kk, ii);
          end
          MODE_OFF: begin
            m_re    = 1'b1;
            m_raddr = elem_addr(kk, jj);
          end
          default: begin
            b_re    = 1'b1;
            b_raddr = elem_addr(kk, cc);
          end
        endcase
        state_nxt = S_DOT_M;
      end

      S_DOT_M: begin
        state_nxt = S_DOT_A;
      end

      S_DOT_A: begin
        acc_nxt   = acc_r - qshift(prod_r);
        k_nxt     = k_r + 1'b1;
        state_nxt = S_DOT_X;
      end

      S_DIAG_END: begin
        if (s_sat[DATA_W-1]) begin
          state_nxt = S_FAIL;
        end else begin
          it_ctrl.start   = 1'b1;
          it_ctrl.op_sqrt = 1'b1;
          it_a            = DIV_W'(s_sat) << FRAC_BITS;
          state_nxt       = S_SQRT;
        end
      end

      S_FAIL: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_row     = ii;
          e_col     = ii;
          e_st      = 1'b1;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SQRT: begin
        if (it_done) begin
          m_we    = 1'b1;
          m_waddr = elem_addr(ii, ii);
          m_wdata = it_res[DATA_W-1:0];
          j_nxt   = i_r + 1'b1;
          if (it_res == '0) begin
            // zero pivot: reciprocal saturates
            dv_nxt    = Q_MAX;
            state_nxt = S_OFF_START;
          end else begin
            it_ctrl.start = 1'b1;
            it_a          = DIV_W'(1) << (2 * FRAC_BITS);
            it_b          = it_res[DATA_W-1:0];
            state_nxt     = S_RECIP;
          end
        end
      end

      S_RECIP: begin
        if (it_done) begin
          dv_nxt    = (|it_res[DIV_W-1:DATA_W-1]) ? Q_MAX : it_res[DATA_W-1:0];
          state_nxt = S_OFF_START;
        end
      end

      S_OFF_START: begin
        if (j_r >= n_r) begin
          if (i_r + 1'b1 == n_r) begin
            state_nxt = S_SOL_START;
          end else begin
            i_nxt     = i_r + 1'b1;
            k_nxt     = '0;
            state_nxt = S_ZERO;
          end
        end else begin
          m_re      = 1'b1;
          m_raddr   = elem_addr(jj, ii);
          state_nxt = S_OFF_LD;
        end
      end

      S_OFF_LD: begin
        acc_nxt   = sext_data(m_rdata);
        k_nxt     = '0;
        mode_nxt  = MODE_OFF;
        state_nxt = S_DOT_X;
      end

      S_OFF_END: begin
        mul_a     = s_sat;
        mul_b     = dv_r;
        state_nxt = S_OFF_MUL;
      end

      S_OFF_MUL: begin
        m_we      = 1'b1;
        m_waddr   = elem_addr(ii, jj);
        m_wdata   = sat32(qshift(prod_r));
        j_nxt     = j_r + 1'b1;
        state_nxt = S_OFF_START;
      end

      S_SOL_START: begin
        i_nxt     = '0;
        c_nxt     = '0;
        state_nxt = (m_r == '0) ? S_EMPTY : S_SOL_ROW;
      end

      S_SOL_ROW: begin
        b_re      = 1'b1;
        b_raddr   = elem_addr(ii, cc);
        state_nxt = S_SOL_LD;
      end

      S_SOL_LD: begin
        acc_nxt   = sext_data(b_rdata);
        k_nxt     = '0;
        mode_nxt  = MODE_SOLVE;
        state_nxt = S_DOT_X;
      end

      S_SOL_END: begin
        s_nxt     = s_sat;
        m_re      = 1'b1;
        m_raddr   = elem_addr(ii, ii);
        state_nxt = S_SOL_PIV;
      end

      S_SOL_PIV: begin
        if (m_rdata == '0) begin
          // zero pivot: saturate by the sign of the sum, or zero for a zero sum
          if (s_r[DATA_W-1]) begin
            res_nxt = Q_MIN;
          end else if (s_r != '0) begin
            res_nxt = Q_MAX;
          end else begin
            res_nxt = '0;
          end
          state_nxt = S_SOL_OUT;
        end else begin
          it_ctrl.start = 1'b1;
          it_a          = DIV_W'(s_abs) << FRAC_BITS;
          it_b          = m_rdata;
          state_nxt     = S_SOL_DIV;
        end
      end

      S_SOL_DIV: begin
        if (it_done) begin
          if (s_r[DATA_W-1]) begin
            if ((|it_res[DIV_W-1:DATA_W]) ||
                (it_res[DATA_W-1] && (|it_res[DATA_W-2:0]))) begin
              res_nxt = Q_MIN;
            end else begin
              res_nxt = ~it_res[DATA_W-1:0] + 1'b1;
            end
          end else begin
            res_nxt = (|it_res[DIV_W-1:DATA_W-1]) ? Q_MAX : it_res[DATA_W-1:0];
          end
          state_nxt = S_SOL_OUT;
        end
      end

      S_SOL_OUT: begin
        if (slot_free) begin
          b_we    = 1'b1;
          b_waddr = elem_addr(ii, cc);
          b_wdata = res_r;
          emit    = 1'b1;
          e_row   = ii;
          e_col   = cc;
          e_val   = res_r;
          e_last  = (i_r + 1'b1 == n_r) && (c_r + 1'b1 == m_r);
          if (i_r + 1'b1 == n_r) begin
            i_nxt     = '0;
            c_nxt     = c_r + 1'b1;
            state_nxt = (c_r + 1'b1 == m_r) ? S_IDLE : S_SOL_ROW;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SOL_ROW;
          end
        end
      end

      S_EMPTY: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_DIAG;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    c_r    <= c_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    dv_r   <= dv_nxt;
    s_r    <= s_nxt;
    res_r  <= res_nxt;
    prod_r <= mul_a * mul_b;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r    <= e_row;
      out_col_r    <= e_col;
      out_value_r  <= e_val;
      out_status_r <= e_st;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;
endmodule

// ===== rtl/chol_checker.sv =====
// port-level checks for the cholesky block, bound to the top level
// depends on chol_pkg and chol_if
module chol_port_checker (
  input logic clk,
  input logic rst_n,
  chol_in_if.sink    in_ch,
  chol_out_if.source out_ch
);
  import chol_pkg::*;

  // a parked result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_value))
    else $error("result changed while stalled");

  // a failure report is always final, zero valued and on the diagonal
  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |->
      out_ch.last && (out_ch.out_value == '0) && (out_ch.out_row == out_ch.out_col))
    else $error("malformed failure result");

  // read and solve runs hold off the next input
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready &&
    (in_ch.command == CMD_SOLVE || in_ch.command == CMD_READ) |=> !in_ch.ready)
    else $error("input taken during a run");

  // a load taken while the output is idle leaves it idle in the next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !out_ch.valid &&
    (in_ch.command == CMD_LOAD_A || in_ch.command == CMD_LOAD_B) |=> !out_ch.valid)
    else $error("load produced a result");
endmodule

bind cholesky_factor_and_solve_top chol_port_checker u_chol_checker (
  .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
);
